/* rtl/sorted_priority_queue_defines.svh */
// Assertion macros for the sorted priority queue.
// Used by the RTL modules that carry concurrent assertions; no dependencies.
`ifndef SORTED_PRIORITY_QUEUE_DEFINES_SVH
`define SORTED_PRIORITY_QUEUE_DEFINES_SVH

// Check that is switched off while reset is asserted.
`define SPQ_ASSERT_RST(label, clk, rst_n, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Check that also holds while reset is asserted.
`define SPQ_ASSERT_ALWAYS(label, clk, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);

`endif

/* rtl/spq_pkg.sv */
// Shared constants, codes and types of the sorted priority queue.
// No dependencies; imported by the interfaces and all modules.
`default_nettype none

package spq_pkg;

  localparam int unsigned CAPACITY       = 16;
  localparam int unsigned DATA_WIDTH     = 32;
  localparam int unsigned PRIORITY_WIDTH = 16;
  localparam int unsigned CNT_W          = $clog2(CAPACITY + 1);

  localparam logic [1:0] CMD_INSERT = 2'd0;
  localparam logic [1:0] CMD_POP    = 2'd1;
  localparam logic [1:0] CMD_PEEK   = 2'd2;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_EMPTY = 2'd1,
    ST_FULL  = 2'd2
  } status_e;

  typedef enum logic {
    S_IDLE = 1'b0,
    S_EXEC = 1'b1
  } state_e;

  typedef logic signed [DATA_WIDTH-1:0]     data_t;
  typedef logic signed [PRIORITY_WIDTH-1:0] prio_t;
  typedef logic [CNT_W-1:0]                 count_t;

  // datapath -> controller
  typedef struct packed {
    logic is_insert;
    logic is_pop;
    logic full;
    logic empty;
  } dp_status_t;

  // controller -> datapath
  typedef struct packed {
    logic    capture;
    logic    load;
    logic    do_insert;
    logic    do_pop;
    status_e res_status;
  } dp_ctrl_t;

endpackage

`default_nettype wire

/* rtl/spq_in_if.sv */
// Command channel of the sorted priority queue: valid/ready plus payload.
// Depends on spq_pkg.
`default_nettype none

interface spq_in_if import spq_pkg::*; ();
  logic         valid;
  logic         ready;
  logic [1:0]   cmd;
  data_t        data_in;
  prio_t        priority_in;

  modport source (output valid, output cmd, output data_in, output priority_in,
                  input ready);
  modport sink   (input valid, input cmd, input data_in, input priority_in,
                  output ready);
endinterface

`default_nettype wire

/* rtl/spq_out_if.sv */
// Result channel of the sorted priority queue: valid/ready plus payload.
// Depends on spq_pkg.
`default_nettype none

interface spq_out_if import spq_pkg::*; ();
  logic         valid;
  logic         ready;
  logic [1:0]   status;
  data_t        data_out;
  prio_t        priority_out;
  logic         is_empty;
  count_t       entry_count;

  modport source (output valid, output status, output data_out, output priority_out,
                  output is_empty, output entry_count, input ready);
  modport sink   (input valid, input status, input data_out, input priority_out,
                  input is_empty, input entry_count, output ready);
endinterface

`default_nettype wire

/* rtl/spq_datapath.sv */
// Entry array, command register and result register of the sorted priority queue.
// Depends on spq_pkg; driven by spq_controller.
`default_nettype none

module spq_datapath import spq_pkg::*; (
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  input  wire dp_ctrl_t   ctrl_i,
  output dp_status_t      status_o,
  input  wire logic [1:0] cmd_i,
  input  wire data_t      data_i,
  input  wire prio_t      prio_i,
  output logic [1:0]      status_out_o,
  output data_t           data_out_o,
  output prio_t           prio_out_o,
  output logic            is_empty_o,
  output count_t          count_out_o
);

  logic [1:0] cmd_q;
  data_t      din_q;
  prio_t      pin_q;
  count_t     count_q, count_d;

  data_t      data_q [CAPACITY];
  prio_t      prio_q [CAPACITY];

  logic [1:0] res_status_q;
  data_t      res_data_q;
  prio_t      res_prio_q;
  logic       res_empty_q;
  count_t     res_count_q;

  logic [CAPACITY-1:0] after;   // slot lies at or behind the insert position
  logic [CAPACITY-1:0] moved;   // occupied slot whose entry goes one place back

  always_ff @(posedge clk_i) begin
    if (ctrl_i.capture) begin
      cmd_q <= cmd_i;
      din_q <= data_i;
      pin_q <= prio_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= '0;
    end else begin
      count_q <= count_d;
    end
  end

  always_comb begin
    count_d = count_q;
    if (ctrl_i.do_insert) begin
      count_d = count_q + count_t'(1);
    end else if (ctrl_i.do_pop) begin
      count_d = count_q - count_t'(1);
    end
  end

  for (genvar i = 0; i < CAPACITY; i++) begin : g_entry
    logic occ;
    assign occ      = count_t'(i) < count_q;
    assign moved[i] = occ && (prio_q[i] > pin_q);
    assign after[i] = moved[i] || (count_t'(i) == count_q);

    if (i == 0) begin : g_head
      always_ff @(posedge clk_i) begin
        if (ctrl_i.do_insert && after[i]) begin
          data_q[i] <= din_q;
          prio_q[i] <= pin_q;
        end else if (ctrl_i.do_pop && (CAPACITY > 1)) begin
          data_q[i] <= data_q[i+1];
          prio_q[i] <= prio_q[i+1];
        end
      end
    end else if (i == CAPACITY - 1) begin : g_tail
      always_ff @(posedge clk_i) begin
        if (ctrl_i.do_insert && after[i]) begin
          data_q[i] <= moved[i-1] ? data_q[i-1] : din_q;
          prio_q[i] <= moved[i-1] ? prio_q[i-1] : pin_q;
        end
      end
    end else begin : g_mid
      always_ff @(posedge clk_i) begin
        if (ctrl_i.do_insert && after[i]) begin
          data_q[i] <= moved[i-1] ? data_q[i-1] : din_q;
          prio_q[i] <= moved[i-1] ? prio_q[i-1] : pin_q;
        end else if (ctrl_i.do_pop) begin
          data_q[i] <= data_q[i+1];
          prio_q[i] <= prio_q[i+1];
        end
      end
    end
  end

  // front entry as reported: new entry if it lands in front, else the old head; zero on empty status
  data_t front_data;
  prio_t front_prio;
  logic  have_front;

  always_comb begin
    have_front = (ctrl_i.res_status != ST_EMPTY);
    if (ctrl_i.do_insert && after[0]) begin
      front_data = din_q;
      front_prio = pin_q;
    end else begin
      front_data = data_q[0];
      front_prio = prio_q[0];
    end
    if (!have_front) begin
      front_data = '0;
      front_prio = '0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctrl_i.load) begin
      res_status_q <= ctrl_i.res_status;
      res_data_q   <= front_data;
      res_prio_q   <= front_prio;
      res_empty_q  <= (count_d == '0);
      res_count_q  <= count_d;
    end
  end

  assign status_o.is_insert = (cmd_q == CMD_INSERT);
  assign status_o.is_pop    = (cmd_q == CMD_POP);
  assign status_o.full      = (count_q == count_t'(CAPACITY));
  assign status_o.empty     = (count_q == '0);

  assign status_out_o = res_status_q;
  assign data_out_o   = res_data_q;
  assign prio_out_o   = res_prio_q;
  assign is_empty_o   = res_empty_q;
  assign count_out_o  = res_count_q;

endmodule

`default_nettype wire

/* rtl/spq_controller.sv */
// Sequencing FSM of the sorted priority queue: accept, execute, result valid.
// Depends on spq_pkg and sorted_priority_queue_defines.svh; drives spq_datapath.
`default_nettype none
`include "sorted_priority_queue_defines.svh"

module spq_controller import spq_pkg::*; (
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  input  wire logic       in_valid_i,
  output logic            in_ready_o,
  output logic            out_valid_o,
  input  wire logic       out_ready_i,
  input  wire dp_status_t status_i,
  output dp_ctrl_t        ctrl_o
);

  state_e state_q, state_d;
  logic   out_valid_q, out_valid_d;
  logic   room;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign room = !out_valid_q || out_ready_i;

  always_comb begin
    state_d           = state_q;
    out_valid_d       = out_valid_q && !out_ready_i;
    in_ready_o        = 1'b0;
    ctrl_o.capture    = 1'b0;
    ctrl_o.load       = 1'b0;
    ctrl_o.do_insert  = 1'b0;
    ctrl_o.do_pop     = 1'b0;
    ctrl_o.res_status = ST_OK;

    if (status_i.is_insert) begin
      if (status_i.full) ctrl_o.res_status = ST_FULL;
    end else if (status_i.empty) begin
      ctrl_o.res_status = ST_EMPTY;
    end

    unique case (state_q)
      S_IDLE: begin
        in_ready_o     = 1'b1;
        ctrl_o.capture = in_valid_i;
        if (in_valid_i) state_d = S_EXEC;
      end
      S_EXEC: begin
        // wait until the result register is free
        if (room) begin
          ctrl_o.load      = 1'b1;
          ctrl_o.do_insert = status_i.is_insert && !status_i.full;
          ctrl_o.do_pop    = status_i.is_pop && !status_i.empty;
          out_valid_d      = 1'b1;
          state_d          = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  assign out_valid_o = out_valid_q;

  `SPQ_ASSERT_RST(a_single_op, clk_i, rst_ni, !(ctrl_o.do_insert && ctrl_o.do_pop), "insert and pop in one cycle")
  `SPQ_ASSERT_RST(a_load_exec, clk_i, rst_ni, ctrl_o.load |-> (state_q == S_EXEC), "result load outside execute")
  `SPQ_ASSERT_RST(a_accept_exec, clk_i, rst_ni, (in_valid_i && in_ready_o) |=> (state_q == S_EXEC), "accepted command not executed")
  `SPQ_ASSERT_RST(a_load_valid, clk_i, rst_ni, ctrl_o.load |=> out_valid_q, "loaded result not presented")
  `SPQ_ASSERT_ALWAYS(a_no_accept_busy, clk_i, (state_q == S_EXEC) |-> !in_ready_o, "command accepted while busy")

endmodule

`default_nettype wire

/* rtl/sorted_priority_queue.sv */
// Sorted priority queue of CAPACITY entries, smallest priority at the front, FIFO among
// equal priorities. A command is taken in the idle state and then executed in the execute
// state, once the result register is free; there all stored priorities are compared against
// the new one at once and, for an insert or pop, the entry array shifts by one place; the
// result then sits in an output register until transferred. The next command is accepted
// while a result still waits. Entry contents have no reset.
// Depends on spq_pkg, spq_in_if, spq_out_if, spq_controller and spq_datapath.
`default_nettype none

module sorted_priority_queue import spq_pkg::*; (
  input  wire logic clk_i,
  input  wire logic rst_ni,
  spq_in_if.sink    in_i,
  spq_out_if.source out_o
);

  dp_ctrl_t   ctrl;
  dp_status_t status;
  logic       in_ready;
  logic       out_valid;

  spq_controller u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_i.valid),
    .in_ready_o  (in_ready),
    .out_valid_o (out_valid),
    .out_ready_i (out_o.ready),
    .status_i    (status),
    .ctrl_o      (ctrl)
  );

  spq_datapath u_dp (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .ctrl_i       (ctrl),
    .status_o     (status),
    .cmd_i        (in_i.cmd),
    .data_i       (in_i.data_in),
    .prio_i       (in_i.priority_in),
    .status_out_o (out_o.status),
    .data_out_o   (out_o.data_out),
    .prio_out_o   (out_o.priority_out),
    .is_empty_o   (out_o.is_empty),
    .count_out_o  (out_o.entry_count)
  );

  assign in_i.ready  = in_ready;
  assign out_o.valid = out_valid;

endmodule

`default_nettype wire

/* dv/spq_checker.sv */
// Scoreboard for the sorted priority queue: watches the command and result channels,
// predicts each result from its own copy of the queue and compares field by field.
// Depends on spq_pkg, spq_in_if and spq_out_if.
`default_nettype none

module spq_checker import spq_pkg::*; (
  input  wire logic clk_i,
  input  wire logic rst_ni,
  spq_in_if         cmd_if,
  spq_out_if        res_if,
  output int        fail_count_o,
  output int        pending_o,
  output int        checked_o,
  output int        full_seen_o,
  output int        empty_seen_o
);
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct {
    status_e status;
    data_t   data;
    prio_t   prio;
    logic    is_empty;
    count_t  count;
  } queue_result_t;

  // Shadow copy of the queue, front at index 0
  data_t shadow_data [CAPACITY];
  prio_t shadow_prio [CAPACITY];
  int    shadow_count;

  queue_result_t expected_results [$];

  int fails;
  int checked;
  int full_seen;
  int empty_seen;

  initial begin
    shadow_count = 0;
    fails        = 0;
    checked      = 0;
    full_seen    = 0;
    empty_seen   = 0;
    fail_count_o = 0;
    pending_o    = 0;
    checked_o    = 0;
    full_seen_o  = 0;
    empty_seen_o = 0;
  end

  // Applies one command to the shadow queue and returns the result it should produce.
  function automatic queue_result_t apply_command(logic [1:0] cmd, data_t din, prio_t pin);
    queue_result_t res;
    int            pos;
    res.status = ST_OK;
    res.data   = '0;
    res.prio   = '0;
    if (cmd == CMD_INSERT) begin
      if (shadow_count >= CAPACITY) begin
        res.status = ST_FULL;
      end else begin
        // new entry goes behind every entry of smaller or equal priority
        pos = 0;
        while (pos < shadow_count && shadow_prio[pos] <= pin) pos++;
        for (int i = shadow_count; i > pos; i--) begin
          shadow_data[i] = shadow_data[i-1];
          shadow_prio[i] = shadow_prio[i-1];
        end
        shadow_data[pos] = din;
        shadow_prio[pos] = pin;
        shadow_count++;
      end
      if (shadow_count > 0) begin
        res.data = shadow_data[0];
        res.prio = shadow_prio[0];
      end
    end else if (shadow_count == 0) begin
      res.status = ST_EMPTY;
    end else begin
      res.data = shadow_data[0];
      res.prio = shadow_prio[0];
      if (cmd == CMD_POP) begin
        for (int i = 0; i + 1 < shadow_count; i++) begin
          shadow_data[i] = shadow_data[i+1];
          shadow_prio[i] = shadow_prio[i+1];
        end
        shadow_count--;
      end
    end
    res.is_empty = (shadow_count == 0);
    res.count    = count_t'(shadow_count);
    return res;
  endfunction

  task automatic compare_result(queue_result_t want);
    if (res_if.status !== want.status) begin
      $error("status: expected %0d, got %0d", want.status, res_if.status);
      fails++;
    end
    if (res_if.data_out !== want.data) begin
      $error("data_out: expected %0d, got %0d", want.data, res_if.data_out);
      fails++;
    end
    if (res_if.priority_out !== want.prio) begin
      $error("priority_out: expected %0d, got %0d", want.prio, res_if.priority_out);
      fails++;
    end
    if (res_if.is_empty !== want.is_empty) begin
      $error("is_empty: expected %0b, got %0b", want.is_empty, res_if.is_empty);
      fails++;
    end
    if (res_if.entry_count !== want.count) begin
      $error("entry_count: expected %0d, got %0d", want.count, res_if.entry_count);
      fails++;
    end
    if (want.status == ST_FULL) full_seen++;
    if (want.status == ST_EMPTY) empty_seen++;
    checked++;
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      shadow_count = 0;
      expected_results.delete();
    end else begin
      // result side first: a result never belongs to a command taken at the same edge
      if (res_if.valid && res_if.ready) begin
        if (expected_results.size() == 0) begin
          $error("result transfer with no command outstanding");
          fails++;
        end else begin
          compare_result(expected_results.pop_front());
        end
      end
      if (cmd_if.valid && cmd_if.ready) begin
        expected_results.push_back(
          apply_command(cmd_if.cmd, cmd_if.data_in, cmd_if.priority_in));
      end
    end
    fail_count_o <= fails;
    pending_o    <= expected_results.size();
    checked_o    <= checked;
    full_seen_o  <= full_seen;
    empty_seen_o <= empty_seen;
  end

endmodule

`default_nettype wire

/* dv/tb_sorted_priority_queue.sv */
// Top of the sorted priority queue testbench: clock, reset, command stimulus with
// bursty traffic, result back-pressure and the verdict.
// Depends on spq_pkg, spq_in_if, spq_out_if, sorted_priority_queue and spq_checker.
`default_nettype none

module tb_sorted_priority_queue;
  import spq_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam logic [1:0] CMD_SPARE   = 2'd3;  // unused code, behaves as peek
  localparam int         NUM_RANDOM  = 1200;
  localparam int         DRAIN_WAIT  = 8;

  logic clk_i  = 1'b0;
  logic rst_ni = 1'b0;

  spq_in_if  in_if ();
  spq_out_if out_if ();

  int fail_count;
  int pending;
  int checked;
  int full_seen;
  int empty_seen;

  int n_insert = 0;
  int n_pop    = 0;
  int n_peek   = 0;
  int burst_left = 0;

  sorted_priority_queue i_dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (in_if),
    .out_o  (out_if)
  );

  spq_checker i_checker (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cmd_if       (in_if),
    .res_if       (out_if),
    .fail_count_o (fail_count),
    .pending_o    (pending),
    .checked_o    (checked),
    .full_seen_o  (full_seen),
    .empty_seen_o (empty_seen)
  );

  always #5 clk_i = ~clk_i;

  initial begin
    in_if.valid       = 1'b0;
    in_if.cmd         = CMD_PEEK;
    in_if.data_in     = '0;
    in_if.priority_in = '0;
    out_if.ready      = 1'b0;
  end

  // Result back-pressure: a randomly drawn mode is held for a random run, then redrawn
  int stall_mode = 0;
  int mode_left  = 0;
  int tick       = 0;
  always @(negedge clk_i) begin
    if (mode_left == 0) begin
      stall_mode = $urandom_range(0, 3);
      mode_left  = $urandom_range(32, 256);
    end
    mode_left--;
    tick++;
    case (stall_mode)
      0:       out_if.ready <= 1'b1;
      1:       out_if.ready <= 1'($urandom_range(0, 1));
      2:       out_if.ready <= ($urandom_range(0, 3) == 0);
      default: out_if.ready <= ((tick % 5) < 3);
    endcase
  end

  // Drives one command and holds it until transferred; idles in random gaps between bursts.
  task automatic send_cmd(logic [1:0] cmd, data_t din, prio_t pin);
    int gap;
    @(negedge clk_i);
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 12);
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
      if (gap > 0) begin
        in_if.valid <= 1'b0;
        repeat (gap) @(negedge clk_i);
      end
    end
    burst_left--;
    in_if.valid       <= 1'b1;
    in_if.cmd         <= cmd;
    in_if.data_in     <= din;
    in_if.priority_in <= pin;
    do @(posedge clk_i); while (!in_if.ready);
    case (cmd)
      CMD_INSERT: n_insert++;
      CMD_POP:    n_pop++;
      default:    n_peek++;
    endcase
  endtask

  function automatic prio_t pick_prio(bit narrow);
    int sel;
    sel = $urandom_range(0, 9);
    if (sel == 0) return prio_t'(16'sh8000);
    if (sel == 1) return prio_t'(16'sh7fff);
    if (narrow || sel < 5) return prio_t'($urandom_range(0, 6) - 3);
    return prio_t'($urandom());
  endfunction

  function automatic data_t pick_data();
    case ($urandom_range(0, 15))
      0:       return data_t'(32'h8000_0000);
      1:       return data_t'(32'h7fff_ffff);
      2:       return data_t'(32'hffff_ffff);
      3:       return '0;
      default: return data_t'($urandom());
    endcase
  endfunction

  initial begin
    int       phase_kind;
    int       phase_len;
    int       roll;
    int       sent;
    bit       narrow;
    logic [1:0] cmd;

    repeat (9) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    // directed: empty queue reads, extremes, ties, fill up and overflow
    send_cmd(CMD_POP,    '0, '0);
    send_cmd(CMD_PEEK,   '0, '0);
    send_cmd(CMD_SPARE,  '0, '0);
    send_cmd(CMD_INSERT, data_t'(32'h8000_0000), prio_t'(16'sh7fff));
    send_cmd(CMD_INSERT, data_t'(32'h7fff_ffff), prio_t'(16'sh8000));
    send_cmd(CMD_INSERT, data_t'(32'h0000_0011), prio_t'(16'sh0000));
    send_cmd(CMD_INSERT, data_t'(32'h0000_0022), prio_t'(16'sh0000));
    send_cmd(CMD_SPARE,  data_t'(32'hffff_ffff), prio_t'(16'shffff));
    send_cmd(CMD_POP,    '0, '0);
    send_cmd(CMD_PEEK,   '0, '0);
    for (int i = 0; i < 14; i++) begin
      send_cmd(CMD_INSERT, data_t'($urandom()), prio_t'(i % 3));
    end

    // random: fill, drain and mixed phases so the queue swings between empty and full
    sent = 0;
    while (sent < NUM_RANDOM) begin
      phase_kind = $urandom_range(0, 2);
      phase_len  = $urandom_range(20, 60);
      narrow     = $urandom_range(0, 1);
      for (int i = 0; i < phase_len; i++) begin
        roll = $urandom_range(0, 99);
        case (phase_kind)
          0:       cmd = (roll < 80) ? CMD_INSERT : (roll < 90) ? CMD_POP : CMD_PEEK;
          1:       cmd = (roll < 15) ? CMD_INSERT : (roll < 85) ? CMD_POP : CMD_PEEK;
          default: cmd = (roll < 45) ? CMD_INSERT : (roll < 85) ? CMD_POP : CMD_PEEK;
        endcase
        if (cmd == CMD_PEEK && $urandom_range(0, 3) == 0) cmd = CMD_SPARE;
        send_cmd(cmd, pick_data(), pick_prio(narrow));
        sent++;
      end
    end

    @(negedge clk_i);
    in_if.valid <= 1'b0;

    while (pending != 0) @(posedge clk_i);
    repeat (DRAIN_WAIT) @(posedge clk_i);

    $display("Sent %0d inserts, %0d pops, %0d peeks; %0d results checked",
             n_insert, n_pop, n_peek, checked);
    $display("Results with full status: %0d, with empty status: %0d", full_seen, empty_seen);
    if (fail_count == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

  initial begin
    #2ms;
    $display("Timeout with %0d results outstanding", pending);
    $display("TEST FAILED");
    $finish;
  end

endmodule

`default_nettype wire
